// File: design/ktmm_pkg.sv
// Shared types and constants of the keyed table min/max tracker.
package ktmm_pkg;

	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;
	localparam int WORD_W  = 1 + KEY_W + VALUE_W;

	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_ERASE = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ERR_OK   = 2'd0,
		ERR_MISS = 2'd1,
		ERR_FULL = 2'd2
	} err_t;

	localparam logic CFG_MODE_IDX = 1'b0;

	typedef struct packed {
		logic [1:0]                opcode;
		logic [KEY_W-1:0]          entry_key;
		logic signed [VALUE_W-1:0] entry_value;
	} item_t;

	typedef struct packed {
		logic [KEY_W-1:0]          top_key;
		logic signed [VALUE_W-1:0] top_value;
		logic                      is_empty;
		logic [1:0]                error_code;
	} result_t;

	typedef struct packed {
		logic capture;
		logic addr_clr;
		logic addr_inc;
		logic rd_en;
		logic wr_clr;
		logic find_en;
		logic rescan_init;
		logic rescan_en;
		logic apply;
		logic clear_table;
		logic result_en;
	} cmd_t;

	typedef struct packed {
		logic issue_end;
		logic sweep_last;
		logic scan_done;
		logic need_rescan;
	} status_t;

endpackage

// File: design/ktmm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ktmm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/ktmm_ctrl.sv
// Controller state machine: sequences clearing sweeps, key search, update and rescans.
module ktmm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         opcode,
	input  logic               cfg_we,
	input  ktmm_pkg::status_t  status,
	output logic               busy,
	output ktmm_pkg::cmd_t     cmd
);

	typedef enum logic [6:0] {
		ST_INIT   = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_FIND   = 7'b0000100,
		ST_APPLY  = 7'b0001000,
		ST_RESCAN = 7'b0010000,
		ST_CLEAR  = 7'b0100000,
		ST_REPLY  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   cfg_scan_q, cfg_scan_d;

	assign busy = (state_q != ST_IDLE) | cfg_we;

	always_comb begin
		state_d    = state_q;
		cfg_scan_d = cfg_scan_q;
		cmd        = '0;
		unique case (state_q)
			ST_INIT: begin
				cmd.wr_clr   = 1'b1;
				cmd.addr_inc = 1'b1;
				if (status.sweep_last) begin
					cmd.addr_clr = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cfg_we) begin
					cmd.rescan_init = 1'b1;
					cmd.addr_clr    = 1'b1;
					cfg_scan_d      = 1'b1;
					state_d         = ST_RESCAN;
				end else if (start) begin
					cmd.capture  = 1'b1;
					cmd.addr_clr = 1'b1;
					cfg_scan_d   = 1'b0;
					unique case (ktmm_pkg::opcode_t'(opcode))
						ktmm_pkg::OP_SET,
						ktmm_pkg::OP_ERASE: state_d = ST_FIND;
						ktmm_pkg::OP_CLEAR: begin
							cmd.clear_table = 1'b1;
							state_d         = ST_CLEAR;
						end
						default: state_d = ST_REPLY;
					endcase
				end
			end
			ST_FIND: begin
				cmd.find_en  = 1'b1;
				cmd.rd_en    = ~status.issue_end;
				cmd.addr_inc = ~status.issue_end;
				if (status.scan_done) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				if (status.need_rescan) begin
					cmd.rescan_init = 1'b1;
					cmd.addr_clr    = 1'b1;
					state_d         = ST_RESCAN;
				end else begin
					state_d = ST_REPLY;
				end
			end
			ST_RESCAN: begin
				// a further mode write restarts the sweep under the new mode
				if (cfg_we && cfg_scan_q) begin
					cmd.rescan_init = 1'b1;
					cmd.addr_clr    = 1'b1;
				end else begin
					cmd.rescan_en = 1'b1;
					cmd.rd_en     = ~status.issue_end;
					cmd.addr_inc  = ~status.issue_end;
					if (status.scan_done) begin
						state_d = cfg_scan_q ? ST_IDLE : ST_REPLY;
					end
				end
			end
			ST_CLEAR: begin
				cmd.wr_clr   = 1'b1;
				cmd.addr_inc = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_REPLY;
				end
			end
			ST_REPLY: begin
				cmd.result_en = 1'b1;
				state_d       = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			cfg_scan_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cfg_scan_q <= cfg_scan_d;
		end
	end

endmodule

// File: design/ktmm_dpath.sv
// Datapath: slot memory, scan pipeline, search and top-entry tracking, result register.
module ktmm_dpath #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ktmm_pkg::cmd_t     cmd,
	input  ktmm_pkg::item_t    item,
	input  logic               mode_we,
	input  logic               mode_wdata,
	output logic               mode,
	output ktmm_pkg::status_t  status,
	output logic               done,
	output ktmm_pkg::result_t  result
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int KW = ktmm_pkg::KEY_W;
	localparam int VW = ktmm_pkg::VALUE_W;

	logic [CW-1:0]          addr_q;
	logic [CW-1:0]          count_q;
	logic                   rd_valid_s1;
	logic [AW-1:0]          rd_addr_s1;
	logic [1:0]             op_q;
	logic [KW-1:0]          key_q;
	logic signed [VW-1:0]   val_q;
	logic                   mode_q;
	logic [KW-1:0]          best_key_q;
	logic signed [VW-1:0]   best_val_q;
	logic                   best_found_q;
	logic                   match_q;
	logic [AW-1:0]          match_idx_q;
	logic                   free_q;
	logic [AW-1:0]          free_idx_q;
	logic [1:0]             err_q;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [ktmm_pkg::WORD_W-1:0] ram_wdata;
	logic [ktmm_pkg::WORD_W-1:0] ram_rdata;
	logic                   r_valid;
	logic [KW-1:0]          r_key;
	logic signed [VW-1:0]   r_val;

	logic                   is_set;
	logic                   is_erase;
	logic                   slot_ok;
	logic [AW-1:0]          slot_idx;
	logic                   was_empty;
	logic                   is_top;
	logic                   best_beats_new;
	logic                   take_scan;

	function automatic logic better(input logic m, input logic signed [VW-1:0] a,
		input logic signed [VW-1:0] b);
		return m ? (a > b) : (a < b);
	endfunction

	assign mode = mode_q;

	assign {r_valid, r_key, r_val} = ram_rdata;

	assign is_set         = (op_q == ktmm_pkg::OP_SET);
	assign is_erase       = (op_q == ktmm_pkg::OP_ERASE);
	assign slot_ok        = match_q | free_q;
	assign slot_idx       = match_q ? match_idx_q : free_idx_q;
	assign was_empty      = (count_q == '0);
	assign is_top         = ~was_empty & (key_q == best_key_q);
	assign best_beats_new = better(mode_q, best_val_q, val_q);
	assign take_scan      = r_valid & (~best_found_q | better(mode_q, r_val, best_val_q) |
		((r_val == best_val_q) & (r_key > best_key_q)));

	always_comb begin
		status.issue_end   = (addr_q == CW'(TABLE_DEPTH));
		status.sweep_last  = (addr_q == CW'(TABLE_DEPTH - 1));
		status.scan_done   = rd_valid_s1 & (rd_addr_s1 == AW'(TABLE_DEPTH - 1));
		status.need_rescan = (is_set & slot_ok & ~was_empty & is_top & best_beats_new) |
			(is_erase & match_q & ((key_q == best_key_q) | (count_q == CW'(1))));
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q[AW-1:0];
		ram_wdata = '0;
		if (cmd.wr_clr) begin
			ram_we = 1'b1;
		end else if (cmd.apply) begin
			ram_waddr = slot_idx;
			ram_we    = (is_set & slot_ok) | (is_erase & match_q);
			ram_wdata = {is_set, key_q, val_q};
		end
	end

	ktmm_ram #(
		.WIDTH(ktmm_pkg::WORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (addr_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			count_q      <= '0;
			rd_valid_s1  <= 1'b0;
			mode_q       <= 1'b0;
			best_key_q   <= '0;
			best_val_q   <= '0;
			best_found_q <= 1'b0;
			match_q      <= 1'b0;
			free_q       <= 1'b0;
			done         <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
			done        <= cmd.result_en;
			if (mode_we) begin
				mode_q <= mode_wdata;
			end
			if (cmd.addr_clr) begin
				addr_q <= '0;
			end else if (cmd.addr_inc) begin
				addr_q <= addr_q + CW'(1);
			end
			if (cmd.capture) begin
				match_q <= 1'b0;
				free_q  <= 1'b0;
			end else if (cmd.find_en && rd_valid_s1) begin
				if (r_valid && (r_key == key_q) && !match_q) begin
					match_q <= 1'b1;
				end
				if (!r_valid && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (cmd.clear_table) begin
				count_q      <= '0;
				best_key_q   <= '0;
				best_val_q   <= '0;
				best_found_q <= 1'b0;
			end else if (cmd.rescan_init) begin
				best_key_q   <= '0;
				best_val_q   <= '0;
				best_found_q <= 1'b0;
			end else if (cmd.rescan_en && rd_valid_s1 && take_scan) begin
				best_key_q   <= r_key;
				best_val_q   <= r_val;
				best_found_q <= 1'b1;
			end
			if (cmd.apply) begin
				if (is_set && slot_ok) begin
					if (!match_q) begin
						count_q <= count_q + CW'(1);
					end
					if (was_empty || !best_beats_new) begin
						best_key_q   <= key_q;
						best_val_q   <= val_q;
						best_found_q <= 1'b1;
					end
				end else if (is_erase && match_q) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_addr_s1 <= addr_q[AW-1:0];
		if (cmd.capture) begin
			op_q  <= item.opcode;
			key_q <= item.entry_key;
			val_q <= item.entry_value;
			err_q <= ktmm_pkg::ERR_OK;
		end
		if (cmd.find_en && rd_valid_s1) begin
			if (r_valid && (r_key == key_q) && !match_q) begin
				match_idx_q <= rd_addr_s1;
			end
			if (!r_valid && !free_q) begin
				free_idx_q <= rd_addr_s1;
			end
		end
		if (cmd.apply) begin
			if (is_set && !slot_ok) begin
				err_q <= ktmm_pkg::ERR_FULL;
			end else if (is_erase && !match_q) begin
				err_q <= ktmm_pkg::ERR_MISS;
			end
		end
		if (cmd.result_en) begin
			result.top_key    <= was_empty ? '0 : best_key_q;
			result.top_value  <= was_empty ? '0 : best_val_q;
			result.is_empty   <= was_empty;
			result.error_code <= err_q;
		end
	end

endmodule

// File: design/keyed_table_min_max_tracker_top.sv
// Top level of the keyed table min/max tracker: APB register, controller and datapath.
//
// Keeps up to TABLE_DEPTH keyed entries in one RAM and reports the top entry (smallest
// value, or largest when mode_max is set) after each item. An item is taken when start is
// high and busy is low; its result appears on result with done high for one cycle and
// cannot be stalled. Every scan walks the slot RAM one entry per cycle: a set or erase
// searches the table, then rescans it when the top entry has to be rescanned (erase of the
// top, or the top overwritten with a worse value); clear sweeps every slot and the unused
// opcode 3 goes straight to its result. After reset a clearing pass runs with busy high,
// and a write of mode_max holds busy for a rescan.
module keyed_table_min_max_tracker_top #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ktmm_pkg::item_t   item,
	output logic              done,
	output ktmm_pkg::result_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	ktmm_pkg::cmd_t    cmd;
	ktmm_pkg::status_t status;
	logic              mode;
	logic              cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & (paddr[2] == ktmm_pkg::CFG_MODE_IDX);
	assign prdata = (paddr[2] == ktmm_pkg::CFG_MODE_IDX) ? {31'd0, mode} : 32'd0;

	ktmm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (item.opcode),
		.cfg_we (cfg_we),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	ktmm_dpath #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.item       (item),
		.mode_we    (cfg_we),
		.mode_wdata (pwdata[0]),
		.mode       (mode),
		.status     (status),
		.done       (done),
		.result     (result)
	);

endmodule
